/* src/ppc_pkg.sv */
package ppc_pkg;

	localparam int NORMAL_FRAC_BITS = 16;

	localparam int NORM_W  = 18;
	localparam int COORD_W = 32;
	localparam int RAD_W   = 31;
	localparam int EPS_W   = 31;
	localparam int DIST_W  = 32;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// exact products and their three-way sum
	localparam int PROD_W = NORM_W + COORD_W;
	localparam int SUM_W  = PROD_W + 2;
	// offset moved up to the product format
	localparam int OFF_W  = COORD_W + NORMAL_FRAC_BITS;
	localparam int FULL_W = ((SUM_W > OFF_W) ? SUM_W : OFF_W) + 1;

	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_SPHERE = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;

	localparam logic [1:0] SIDE_ON    = 2'd0;
	localparam logic [1:0] SIDE_FRONT = 2'd1;
	localparam logic [1:0] SIDE_BACK  = 2'd2;

	localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd3;
	localparam logic [IDX_W-1:0] REG_EPSILON  = 3'd4;

	localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = NORM_W'(65536);
	localparam logic [EPS_W-1:0]         EPSILON_RESET  = EPS_W'(66);

	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [RAD_W-1:0] radius;
	} ctrl_t;

endpackage

/* src/plane_primitive_classifier.sv */
// Plane classifier for points, spheres and axis-aligned boxes.
// Configuration: write cfg_data into register cfg_index (0 normal_x, 1 normal_y,
// 2 normal_z, 3 plane_offset, 4 epsilon) on a cycle with cfg_we high. Write
// only while no item is in flight.
// Input: an item transfers on a clock edge with start high and busy low. busy
// is always low, so a new item may be given every cycle.
// Output: done pulses for one cycle with side and signed_distance valid; the
// result of an accepted item passes the four register stages in order:
// products, corner select and sum, offset subtract, compare and saturate.
// Throughput is one item per clock.
// The receiver cannot hold results off; there is no backpressure.
// Reset clears the pipeline valid bits and loads the register defaults
// (normal 0,0,1.0, offset 0, epsilon 66).
module plane_primitive_classifier (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ppc_pkg::IDX_W-1:0]             cfg_index,
	input  logic [ppc_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            req_type,
	input  logic signed [ppc_pkg::COORD_W-1:0]    first_x,
	input  logic signed [ppc_pkg::COORD_W-1:0]    first_y,
	input  logic signed [ppc_pkg::COORD_W-1:0]    first_z,
	input  logic signed [ppc_pkg::COORD_W-1:0]    second_x,
	input  logic signed [ppc_pkg::COORD_W-1:0]    second_y,
	input  logic signed [ppc_pkg::COORD_W-1:0]    second_z,
	input  logic [ppc_pkg::RAD_W-1:0]             radius,
	output logic                                  done,
	output logic [1:0]                            side,
	output logic signed [ppc_pkg::DIST_W-1:0]     signed_distance
);

	localparam int FW  = ppc_pkg::FULL_W;
	localparam int NFB = ppc_pkg::NORMAL_FRAC_BITS;

	localparam logic signed [FW-1:0] Q_MAX =
		FW'({1'b0, {(ppc_pkg::DIST_W-1){1'b1}}});
	localparam logic signed [FW-1:0] Q_MIN = -Q_MAX - FW'(1);

	logic signed [ppc_pkg::NORM_W-1:0]  normal_x_q, normal_y_q, normal_z_q;
	logic signed [ppc_pkg::COORD_W-1:0] offset_q;
	logic [ppc_pkg::EPS_W-1:0]          epsilon_q;

	ppc_pkg::ctrl_t                     ctrl_in, ctrl_s2, ctrl_s3;
	logic signed [ppc_pkg::SUM_W-1:0]   lo_s2, hi_s2;
	logic signed [FW-1:0]               dlo_s3, dhi_s3;
	logic signed [FW-1:0]               off_full, eps_full, rad_full, q;

	logic                               done_s4;
	logic [1:0]                         side_s4, side_nxt;
	logic signed [ppc_pkg::DIST_W-1:0]  dist_s4, dist_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= '0;
			normal_z_q <= ppc_pkg::NORMAL_Z_RESET;
			offset_q   <= '0;
			epsilon_q  <= ppc_pkg::EPSILON_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ppc_pkg::REG_NORMAL_X: normal_x_q <= cfg_data[ppc_pkg::NORM_W-1:0];
				ppc_pkg::REG_NORMAL_Y: normal_y_q <= cfg_data[ppc_pkg::NORM_W-1:0];
				ppc_pkg::REG_NORMAL_Z: normal_z_q <= cfg_data[ppc_pkg::NORM_W-1:0];
				ppc_pkg::REG_OFFSET:   offset_q   <= cfg_data[ppc_pkg::COORD_W-1:0];
				ppc_pkg::REG_EPSILON:  epsilon_q  <= cfg_data[ppc_pkg::EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_comb begin
		ctrl_in.valid  = start && !busy;
		ctrl_in.kind   = req_type;
		ctrl_in.radius = radius;
	end

	ppc_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_in),
		.nx       (normal_x_q),
		.ny       (normal_y_q),
		.nz       (normal_z_q),
		.ax       (first_x),
		.ay       (first_y),
		.az       (first_z),
		.bx       (second_x),
		.by       (second_y),
		.bz       (second_z),
		.ctrl_out (ctrl_s2),
		.lo       (lo_s2),
		.hi       (hi_s2)
	);

	assign off_full = FW'(offset_q) <<< NFB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		dlo_s3 <= FW'(lo_s2) - off_full;
		dhi_s3 <= FW'(hi_s2) - off_full;
	end

	// tolerances scaled to the product format, compares stay exact
	always_comb begin
		eps_full = signed'(FW'(epsilon_q)) <<< NFB;
		rad_full = signed'(FW'(ctrl_s3.radius)) <<< NFB;
		// arithmetic shift is the floor toward minus infinity
		q        = dlo_s3 >>> NFB;
		if (q > Q_MAX) begin
			dist_nxt = Q_MAX[ppc_pkg::DIST_W-1:0];
		end else if (q < Q_MIN) begin
			dist_nxt = Q_MIN[ppc_pkg::DIST_W-1:0];
		end else begin
			dist_nxt = q[ppc_pkg::DIST_W-1:0];
		end
		side_nxt = ppc_pkg::SIDE_ON;
		case (ctrl_s3.kind)
			ppc_pkg::KIND_POINT: begin
				if (dlo_s3 > eps_full) begin
					side_nxt = ppc_pkg::SIDE_FRONT;
				end else if (dlo_s3 < -eps_full) begin
					side_nxt = ppc_pkg::SIDE_BACK;
				end
			end
			ppc_pkg::KIND_SPHERE: begin
				if (dlo_s3 >= rad_full) begin
					side_nxt = ppc_pkg::SIDE_FRONT;
				end else if (dlo_s3 <= -rad_full) begin
					side_nxt = ppc_pkg::SIDE_BACK;
				end
			end
			ppc_pkg::KIND_BOX: begin
				dist_nxt = '0;
				if (!dlo_s3[FW-1]) begin
					side_nxt = ppc_pkg::SIDE_FRONT;
				end else if (dhi_s3[FW-1] || dhi_s3 == '0) begin
					side_nxt = ppc_pkg::SIDE_BACK;
				end
			end
			default: begin
				dist_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_nxt;
		dist_s4 <= dist_nxt;
	end

	assign done            = done_s4;
	assign side            = side_s4;
	assign signed_distance = dist_s4;

endmodule

/* src/ppc_dot.sv */
module ppc_dot (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ppc_pkg::ctrl_t                       ctrl_in,
	input  logic signed [ppc_pkg::NORM_W-1:0]    nx,
	input  logic signed [ppc_pkg::NORM_W-1:0]    ny,
	input  logic signed [ppc_pkg::NORM_W-1:0]    nz,
	input  logic signed [ppc_pkg::COORD_W-1:0]   ax,
	input  logic signed [ppc_pkg::COORD_W-1:0]   ay,
	input  logic signed [ppc_pkg::COORD_W-1:0]   az,
	input  logic signed [ppc_pkg::COORD_W-1:0]   bx,
	input  logic signed [ppc_pkg::COORD_W-1:0]   by,
	input  logic signed [ppc_pkg::COORD_W-1:0]   bz,
	output ppc_pkg::ctrl_t                       ctrl_out,
	output logic signed [ppc_pkg::SUM_W-1:0]     lo,
	output logic signed [ppc_pkg::SUM_W-1:0]     hi
);

	logic signed [ppc_pkg::PROD_W-1:0] pax_s1, pay_s1, paz_s1;
	logic signed [ppc_pkg::PROD_W-1:0] pbx_s1, pby_s1, pbz_s1;
	logic [2:0]                        npos_s1;
	ppc_pkg::ctrl_t                    ctrl_s1, ctrl_s2;
	logic signed [ppc_pkg::SUM_W-1:0]  lo_s2, hi_s2;

	logic signed [ppc_pkg::PROD_W-1:0] lx, ly, lz, hx, hy, hz;
	logic                              box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		pax_s1  <= nx * ax;
		pay_s1  <= ny * ay;
		paz_s1  <= nz * az;
		pbx_s1  <= nx * bx;
		pby_s1  <= ny * by;
		pbz_s1  <= nz * bz;
		npos_s1 <= {nz > 0, ny > 0, nx > 0};
	end

	// boxes take the min corner into the low extreme on a positive axis;
	// points and spheres always use the first corner for the low extreme
	always_comb begin
		box = (ctrl_s1.kind == ppc_pkg::KIND_BOX);
		lx  = (!box || npos_s1[0]) ? pax_s1 : pbx_s1;
		hx  = npos_s1[0] ? pbx_s1 : pax_s1;
		ly  = (!box || npos_s1[1]) ? pay_s1 : pby_s1;
		hy  = npos_s1[1] ? pby_s1 : pay_s1;
		lz  = (!box || npos_s1[2]) ? paz_s1 : pbz_s1;
		hz  = npos_s1[2] ? pbz_s1 : paz_s1;
	end

	always_ff @(posedge clk) begin
		lo_s2 <= ppc_pkg::SUM_W'(lx) + ppc_pkg::SUM_W'(ly) + ppc_pkg::SUM_W'(lz);
		hi_s2 <= ppc_pkg::SUM_W'(hx) + ppc_pkg::SUM_W'(hy) + ppc_pkg::SUM_W'(hz);
	end

	assign ctrl_out = ctrl_s2;
	assign lo       = lo_s2;
	assign hi       = hi_s2;

endmodule

/* src/ppc_checker.sv */
module ppc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          req_type,
	input logic                                done,
	input logic [1:0]                          side,
	input logic signed [ppc_pkg::DIST_W-1:0]   signed_distance
);

	logic [3:0] rst_hist_q;
	logic       clean4;

	// out of reset long enough for a full pass through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_hist_q <= '0;
		end else begin
			rst_hist_q <= {rst_hist_q[2:0], 1'b1};
		end
	end

	assign clean4 = &rst_hist_q;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		clean4 |-> (done == $past(start && !busy, 4)))
		else $error("result strobe does not match a transfer four cycles back");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (side == ppc_pkg::SIDE_ON || side == ppc_pkg::SIDE_FRONT ||
			side == ppc_pkg::SIDE_BACK))
		else $error("bad side code");

	a_box_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(clean4 && done && $past(req_type, 4) != ppc_pkg::KIND_POINT &&
			$past(req_type, 4) != ppc_pkg::KIND_SPHERE) |->
			(signed_distance == '0))
		else $error("nonzero distance for box or unused request");

endmodule

bind plane_primitive_classifier ppc_checker u_ppc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.req_type        (req_type),
	.done            (done),
	.side            (side),
	.signed_distance (signed_distance)
);
